>>> rtl/sfhp_pkg.sv
// Shared types, constants and coefficient tables for the first-harmonic power block.
package sfhp_pkg;

   localparam int NUM_CHANNELS_DEFAULT = 4;
   localparam int RING_DEPTH           = 15;
   localparam int TABLE_LENGTH         = 12;
   localparam int SAMPLES_PER_BLOCK    = 8;
   localparam int CHANNEL_W            = 2;
   localparam int SAMPLE_W             = 22;
   localparam int COEF_W               = 11;
   localparam int PROD_W               = 32;
   localparam int ACC_W                = 36;
   localparam int PRE_SHIFT            = 5;
   localparam int SH_W                 = ACC_W - PRE_SHIFT;
   localparam int SQ_W                 = 2 * SH_W;
   localparam int TOTAL_W              = SQ_W + 1;
   localparam int OUT_SHIFT            = 14;
   localparam int POWER_W              = 46;
   localparam int IDX_W                = 4;
   localparam int STEP_W               = $clog2(SAMPLES_PER_BLOCK);
   localparam int HEAD_HALVED          = 3;
   localparam int TAIL_HALVED          = RING_DEPTH - 3;
   localparam int PHASE_PRE            = 8;
   localparam int PHASE_ADVANCE        = 4;
   localparam int START_ADVANCE        = SAMPLES_PER_BLOCK - 1;
   localparam int REQ_TDATA_W          = SAMPLES_PER_BLOCK * SAMPLE_W;
   localparam int RSP_TDATA_W          = ((POWER_W + 7) / 8) * 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_MUL,
      ST_DRAIN,
      ST_SQUARE,
      ST_SUM,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic              load;
      logic              setup;
      logic              clear;
      logic              mul;
      logic [STEP_W-1:0] step;
      logic              square;
      logic              sum;
      logic              out_load;
   } cmd_type;

   typedef struct packed {
      logic chan_ok;
   } status_type;

   function automatic logic signed [COEF_W-1:0] cos_coef(input logic [IDX_W-1:0] idx);
      logic signed [COEF_W-1:0] c;
      case (idx)
         4'd0:    c = -11'sd591;
         4'd1:    c = -11'sd683;
         4'd2:    c = -11'sd591;
         4'd3:    c = -11'sd341;
         4'd4:    c = 11'sd0;
         4'd5:    c = 11'sd341;
         4'd6:    c = 11'sd591;
         4'd7:    c = 11'sd683;
         4'd8:    c = 11'sd591;
         4'd9:    c = 11'sd341;
         4'd10:   c = 11'sd0;
         4'd11:   c = -11'sd341;
         default: c = 11'sd0;
      endcase
      return c;
   endfunction

   function automatic logic signed [COEF_W-1:0] sin_coef(input logic [IDX_W-1:0] idx);
      logic signed [COEF_W-1:0] c;
      case (idx)
         4'd0:    c = 11'sd341;
         4'd1:    c = 11'sd0;
         4'd2:    c = -11'sd341;
         4'd3:    c = -11'sd591;
         4'd4:    c = -11'sd683;
         4'd5:    c = -11'sd591;
         4'd6:    c = -11'sd341;
         4'd7:    c = 11'sd0;
         4'd8:    c = 11'sd341;
         4'd9:    c = 11'sd591;
         4'd10:   c = 11'sd683;
         4'd11:   c = 11'sd591;
         default: c = 11'sd0;
      endcase
      return c;
   endfunction

   // halve by arithmetic shift when asked, then sign-extend to accumulator width
   function automatic logic signed [ACC_W-1:0] widen_term(input logic signed [PROD_W-1:0] v,
                                                          input logic half);
      logic signed [PROD_W-1:0] h;
      h = half ? (v >>> 1) : v;
      return {{(ACC_W-PROD_W){h[PROD_W-1]}}, h};
   endfunction

endpackage

>>> rtl/sliding_first_harmonic_power.sv
// Sliding first-harmonic power: top level joining controller and datapath.
// Each accepted beat carries eight samples for one channel and yields one power beat.
// A beat holds the block from acceptance until ready returns, so a new beat is taken only
// after the last one has passed through its steps: a setup step, the multiply steps (one
// sample per cycle through a shared cosine and sine multiplier pair, with the older ring
// entries read from the product memory alongside), a drain, a squaring, a sum and an output
// step, which waits while an earlier result is stalled; the power beat is then valid. A
// finished result waits in the output register while the next beat is taken. A beat for
// a channel number beyond the configured count goes from setup to the output step, returns
// zero and changes no per-channel state.
module sliding_first_harmonic_power #(
   parameter int NUM_CHANNELS = sfhp_pkg::NUM_CHANNELS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // sample_0 .. sample_7, 22 bits each
   input  logic [sfhp_pkg::REQ_TDATA_W-1:0] req_tdata,
   // channel
   input  logic [sfhp_pkg::CHANNEL_W-1:0]   req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // harmonic_power, zero padded
   output logic [sfhp_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   sfhp_pkg::cmd_type              cmd;
   sfhp_pkg::status_type           status;
   logic [sfhp_pkg::POWER_W-1:0]   harmonic_power;

   sfhp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sfhp_datapath #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .channel        (req_tuser),
      .samples        (req_tdata),
      .harmonic_power (harmonic_power)
   );

   assign rsp_tdata = {{(sfhp_pkg::RSP_TDATA_W - sfhp_pkg::POWER_W){1'b0}}, harmonic_power};

endmodule

>>> rtl/sfhp_ctrl.sv
// Sequencing state machine for the first-harmonic power block.
module sfhp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  sfhp_pkg::status_type status,
   output sfhp_pkg::cmd_type    cmd
);

   localparam logic [sfhp_pkg::STEP_W-1:0] LAST_STEP =
      sfhp_pkg::STEP_W'(sfhp_pkg::SAMPLES_PER_BLOCK - 1);

   sfhp_pkg::state_type             state_ff, state_in;
   logic [sfhp_pkg::STEP_W-1:0]     step_ff, step_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sfhp_pkg::ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         sfhp_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = sfhp_pkg::ST_SETUP;
            end
         end
         sfhp_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
            step_in   = '0;
            if (status.chan_ok) begin
               state_in = sfhp_pkg::ST_MUL;
            end else begin
               cmd.clear = 1'b1;
               state_in  = sfhp_pkg::ST_FINISH;
            end
         end
         sfhp_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            cmd.step = step_ff;
            step_in  = step_ff + sfhp_pkg::STEP_W'(1);
            if (step_ff == LAST_STEP) begin
               state_in = sfhp_pkg::ST_DRAIN;
            end
         end
         sfhp_pkg::ST_DRAIN: begin
            state_in = sfhp_pkg::ST_SQUARE;
         end
         sfhp_pkg::ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = sfhp_pkg::ST_SUM;
         end
         sfhp_pkg::ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = sfhp_pkg::ST_FINISH;
         end
         sfhp_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = sfhp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sfhp_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

>>> rtl/sfhp_datapath.sv
// Multipliers, product rings, accumulators and squaring datapath.
module sfhp_datapath #(
   parameter int NUM_CHANNELS = sfhp_pkg::NUM_CHANNELS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sfhp_pkg::cmd_type                   cmd,
   output sfhp_pkg::status_type                status,
   input  logic [sfhp_pkg::CHANNEL_W-1:0]      channel,
   input  logic [sfhp_pkg::REQ_TDATA_W-1:0]    samples,
   output logic [sfhp_pkg::POWER_W-1:0]        harmonic_power
);

   localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int MEM_DEPTH = NUM_CHANNELS * sfhp_pkg::RING_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int IDX_W     = sfhp_pkg::IDX_W;
   localparam int PROD_W    = sfhp_pkg::PROD_W;
   localparam int ACC_W     = sfhp_pkg::ACC_W;
   localparam int SH_W      = sfhp_pkg::SH_W;
   localparam int SQ_W      = sfhp_pkg::SQ_W;
   localparam int TOTAL_W   = sfhp_pkg::TOTAL_W;
   localparam logic [IDX_W-1:0] TAB_LAST  = IDX_W'(sfhp_pkg::TABLE_LENGTH - 1);
   localparam logic [IDX_W-1:0] RING_LAST = IDX_W'(sfhp_pkg::RING_DEPTH - 1);
   localparam logic [TOTAL_W-1:0] ROUND   = TOTAL_W'(1) << (sfhp_pkg::OUT_SHIFT - 1);

   logic [sfhp_pkg::CHANNEL_W-1:0]         chan_ff;
   logic signed [sfhp_pkg::SAMPLE_W-1:0]   samp_ff [sfhp_pkg::SAMPLES_PER_BLOCK];
   logic [IDX_W-1:0]                       phase_ff [NUM_CHANNELS];
   logic [IDX_W-1:0]                       start_ff [NUM_CHANNELS];
   logic [CH_W-1:0]                        ch_idx;
   logic [IDX_W-1:0]                       cur_phase, cur_start;
   logic [ADDR_W-1:0]                      base_ff;
   logic [IDX_W-1:0]                       tab_ff, wr_ff, rd_ff;

   logic signed [PROD_W-1:0]               cos_mem [MEM_DEPTH];
   logic signed [PROD_W-1:0]               sin_mem [MEM_DEPTH];
   logic [MEM_DEPTH-1:0]                   written_ff;

   logic signed [sfhp_pkg::SAMPLE_W-1:0]   samp_sel;
   logic signed [PROD_W:0]                 full_cos, full_sin;
   logic signed [PROD_W-1:0]               prod_cos_ff, prod_sin_ff;
   logic                                   prod_vld_ff, prod_half_ff;
   logic [ADDR_W-1:0]                      prod_addr_ff;
   logic [ADDR_W-1:0]                      rd_addr;
   logic signed [PROD_W-1:0]               rd_cos_ff, rd_sin_ff;
   logic                                   rd_vld_ff, rd_ok_ff, rd_half_ff;
   logic                                   rd_go, new_half, old_half;

   logic signed [ACC_W-1:0]                new_cos, new_sin, old_cos, old_sin;
   logic signed [ACC_W-1:0]                acc_cos_ff, acc_sin_ff;
   logic signed [SH_W-1:0]                 sh_cos, sh_sin;
   logic signed [SQ_W-1:0]                 sq_cos_ff, sq_sin_ff;
   logic [TOTAL_W-1:0]                     total;
   logic [sfhp_pkg::POWER_W-1:0]           power_ff, out_ff;

   assign status.chan_ok = (int'(chan_ff) < NUM_CHANNELS);
   assign ch_idx         = CH_W'(chan_ff);
   assign cur_phase      = phase_ff[ch_idx];
   assign cur_start      = start_ff[ch_idx];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         chan_ff <= channel;
         for (int i = 0; i < sfhp_pkg::SAMPLES_PER_BLOCK; i++) begin
            samp_ff[i] <= samples[i*sfhp_pkg::SAMPLE_W +: sfhp_pkg::SAMPLE_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            phase_ff[c] <= '0;
            start_ff[c] <= '0;
         end
      end else if (cmd.setup && status.chan_ok) begin
         phase_ff[ch_idx] <= (cur_phase >= IDX_W'(sfhp_pkg::TABLE_LENGTH - sfhp_pkg::PHASE_ADVANCE))
                             ? cur_phase - IDX_W'(sfhp_pkg::TABLE_LENGTH - sfhp_pkg::PHASE_ADVANCE)
                             : cur_phase + IDX_W'(sfhp_pkg::PHASE_ADVANCE);
         start_ff[ch_idx] <= (cur_start >= IDX_W'(sfhp_pkg::RING_DEPTH - sfhp_pkg::START_ADVANCE))
                             ? cur_start - IDX_W'(sfhp_pkg::RING_DEPTH - sfhp_pkg::START_ADVANCE)
                             : cur_start + IDX_W'(sfhp_pkg::START_ADVANCE);
      end
   end

   // walk table index, write slot and read slot
   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         base_ff <= ADDR_W'(int'(ch_idx) * sfhp_pkg::RING_DEPTH);
         tab_ff  <= (cur_phase >= IDX_W'(sfhp_pkg::TABLE_LENGTH - sfhp_pkg::PHASE_PRE))
                    ? cur_phase - IDX_W'(sfhp_pkg::TABLE_LENGTH - sfhp_pkg::PHASE_PRE)
                    : cur_phase + IDX_W'(sfhp_pkg::PHASE_PRE);
         wr_ff   <= cur_start;
         rd_ff   <= (cur_start >= IDX_W'(sfhp_pkg::RING_DEPTH - sfhp_pkg::SAMPLES_PER_BLOCK))
                    ? cur_start - IDX_W'(sfhp_pkg::RING_DEPTH - sfhp_pkg::SAMPLES_PER_BLOCK)
                    : cur_start + IDX_W'(sfhp_pkg::SAMPLES_PER_BLOCK);
      end else if (cmd.mul) begin
         tab_ff <= (tab_ff == TAB_LAST) ? '0 : tab_ff + IDX_W'(1);
         wr_ff  <= (wr_ff == RING_LAST) ? '0 : wr_ff + IDX_W'(1);
         rd_ff  <= (rd_ff == RING_LAST) ? '0 : rd_ff + IDX_W'(1);
      end
   end

   assign samp_sel = samp_ff[cmd.step];
   assign full_cos = (PROD_W+1)'(samp_sel) * (PROD_W+1)'(sfhp_pkg::cos_coef(tab_ff));
   assign full_sin = (PROD_W+1)'(samp_sel) * (PROD_W+1)'(sfhp_pkg::sin_coef(tab_ff));
   assign rd_addr  = base_ff + ADDR_W'(rd_ff);
   assign new_half = (int'(cmd.step) < sfhp_pkg::HEAD_HALVED);
   assign old_half = (int'(cmd.step) + sfhp_pkg::SAMPLES_PER_BLOCK >= sfhp_pkg::TAIL_HALVED);
   assign rd_go    = cmd.mul &&
                     (int'(cmd.step) + sfhp_pkg::SAMPLES_PER_BLOCK < sfhp_pkg::RING_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         rd_vld_ff   <= 1'b0;
      end else begin
         prod_vld_ff <= cmd.mul;
         rd_vld_ff   <= rd_go;
      end
   end

   always_ff @(posedge clock) begin
      prod_cos_ff  <= full_cos[PROD_W-1:0];
      prod_sin_ff  <= full_sin[PROD_W-1:0];
      prod_half_ff <= new_half;
      prod_addr_ff <= base_ff + ADDR_W'(wr_ff);
      rd_half_ff   <= old_half;
   end

   always_ff @(posedge clock) begin
      if (prod_vld_ff) begin
         cos_mem[prod_addr_ff] <= prod_cos_ff;
         sin_mem[prod_addr_ff] <= prod_sin_ff;
      end
      if (rd_go) begin
         rd_cos_ff <= cos_mem[rd_addr];
         rd_sin_ff <= sin_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         rd_ok_ff   <= 1'b0;
      end else begin
         if (prod_vld_ff) begin
            written_ff[prod_addr_ff] <= 1'b1;
         end
         if (rd_go) begin
            rd_ok_ff <= written_ff[rd_addr];
         end
      end
   end

   assign new_cos = sfhp_pkg::widen_term(prod_cos_ff, prod_half_ff);
   assign new_sin = sfhp_pkg::widen_term(prod_sin_ff, prod_half_ff);
   assign old_cos = (rd_vld_ff && rd_ok_ff) ? sfhp_pkg::widen_term(rd_cos_ff, rd_half_ff) : '0;
   assign old_sin = (rd_vld_ff && rd_ok_ff) ? sfhp_pkg::widen_term(rd_sin_ff, rd_half_ff) : '0;

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         acc_cos_ff <= '0;
         acc_sin_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_cos_ff <= acc_cos_ff + new_cos + old_cos;
         acc_sin_ff <= acc_sin_ff + new_sin + old_sin;
      end
   end

   assign sh_cos = acc_cos_ff[ACC_W-1:sfhp_pkg::PRE_SHIFT];
   assign sh_sin = acc_sin_ff[ACC_W-1:sfhp_pkg::PRE_SHIFT];

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         sq_cos_ff <= SQ_W'(sh_cos) * SQ_W'(sh_cos);
         sq_sin_ff <= SQ_W'(sh_sin) * SQ_W'(sh_sin);
      end
   end

   assign total = {1'b0, sq_cos_ff} + {1'b0, sq_sin_ff} + ROUND;

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         power_ff <= '0;
      end else if (cmd.sum) begin
         power_ff <= total[sfhp_pkg::OUT_SHIFT +: sfhp_pkg::POWER_W];
      end
      if (cmd.out_load) begin
         out_ff <= power_ff;
      end
   end

   assign harmonic_power = out_ff;

endmodule

>>> rtl/sfhp_checker.sv
// Port-level checks for the first-harmonic power block, bound to the top level.
module sfhp_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [sfhp_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat dropped or changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second beat taken while one is in progress");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[sfhp_pkg::RSP_TDATA_W-1:sfhp_pkg::POWER_W] == '0)
      else $error("padding bits of result beat not zero");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

endmodule

bind sliding_first_harmonic_power sfhp_checker u_sfhp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> test/harmonic_power_checker.sv
`timescale 1ns / 100ps
// Checker that predicts the first-harmonic power of each sample block and compares result beats.
module harmonic_power_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   // sample_0 .. sample_7, 22 bits each
   input  logic [sfhp_pkg::REQ_TDATA_W-1:0] req_tdata,
   // channel
   input  logic [sfhp_pkg::CHANNEL_W-1:0]   req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // harmonic_power, zero padded
   input  logic [sfhp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output int                               mismatch_count,
   output int                               outstanding
);
   import sfhp_pkg::*;

   localparam int CHANNELS = NUM_CHANNELS_DEFAULT;

   logic signed [PROD_W-1:0] cos_ring [CHANNELS][RING_DEPTH];
   logic signed [PROD_W-1:0] sin_ring [CHANNELS][RING_DEPTH];
   logic [IDX_W-1:0]         phase_of [CHANNELS];
   logic [IDX_W-1:0]         start_of [CHANNELS];
   logic [POWER_W-1:0]       expected_power [$];

   function automatic int cos_weight(input int idx);
      case (idx)
         0, 2:    cos_weight = -591;
         1:       cos_weight = -683;
         3, 11:   cos_weight = -341;
         5, 9:    cos_weight = 341;
         6, 8:    cos_weight = 591;
         7:       cos_weight = 683;
         default: cos_weight = 0;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [POWER_W-1:0] want,
                                  input logic [POWER_W-1:0] got);
      mismatch_count++;
      $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
   endtask

   task automatic predict_power(input int ch, input logic [REQ_TDATA_W-1:0] blk,
                                output logic [POWER_W-1:0] power);
      int q;
      int s;
      int t;
      int r;
      logic signed [63:0] x;
      logic signed [63:0] c_term;
      logic signed [63:0] s_term;
      logic signed [63:0] c_sum;
      logic signed [63:0] s_sum;
      logic [63:0]        total;
      if (ch >= CHANNELS) begin
         power = '0;
         return;
      end
      q = (int'(phase_of[ch]) + PHASE_PRE) % TABLE_LENGTH;
      s = int'(start_of[ch]);
      for (int i = 0; i < SAMPLES_PER_BLOCK; i++) begin
         x = 64'($signed(blk[i*SAMPLE_W +: SAMPLE_W]));
         t = (q + i) % TABLE_LENGTH;
         r = (s + i) % RING_DEPTH;
         c_term = x * cos_weight(t);
         s_term = x * cos_weight((t + 9) % TABLE_LENGTH);
         cos_ring[ch][r] = c_term[PROD_W-1:0];
         sin_ring[ch][r] = s_term[PROD_W-1:0];
      end
      c_sum = 0;
      s_sum = 0;
      for (int k = 0; k < RING_DEPTH; k++) begin
         r = (s + k) % RING_DEPTH;
         c_term = 64'(cos_ring[ch][r]);
         s_term = 64'(sin_ring[ch][r]);
         if (k < HEAD_HALVED || k >= TAIL_HALVED) begin
            c_term = c_term >>> 1;
            s_term = s_term >>> 1;
         end
         c_sum = c_sum + c_term;
         s_sum = s_sum + s_term;
      end
      c_sum = c_sum >>> PRE_SHIFT;
      s_sum = s_sum >>> PRE_SHIFT;
      total = c_sum * c_sum + s_sum * s_sum + (64'd1 << (OUT_SHIFT - 1));
      power = total[OUT_SHIFT +: POWER_W];
      start_of[ch] = IDX_W'((s + START_ADVANCE) % RING_DEPTH);
      phase_of[ch] = IDX_W'((q + SAMPLES_PER_BLOCK) % TABLE_LENGTH);
   endtask

   always @(posedge clock) begin : watch
      logic [POWER_W-1:0] power;
      logic [POWER_W-1:0] want;
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            phase_of[c] = '0;
            start_of[c] = '0;
            for (int k = 0; k < RING_DEPTH; k++) begin
               cos_ring[c][k] = '0;
               sin_ring[c][k] = '0;
            end
         end
         expected_power.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_power.size() == 0) begin
               report_mismatch("unexpected power beat", '0, rsp_tdata[POWER_W-1:0]);
            end else begin
               want = expected_power.pop_front();
               if (rsp_tdata[POWER_W-1:0] !== want)
                  report_mismatch("harmonic_power", want, rsp_tdata[POWER_W-1:0]);
            end
         end
         if (req_tvalid && req_tready) begin
            predict_power(int'(req_tuser), req_tdata, power);
            expected_power.push_back(power);
         end
      end
      outstanding <= expected_power.size();
   end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// Testbench top: drives sample blocks into the first-harmonic power block and gives the verdict.
module tb_top;
   import sfhp_pkg::*;

   localparam int RANDOM_BLOCKS = 1600;
   localparam int CALM_BLOCKS   = 250;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   // sample_0 .. sample_7, 22 bits each
   logic [REQ_TDATA_W-1:0] req_tdata;
   // channel
   logic [CHANNEL_W-1:0]   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // harmonic_power, zero padded
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   int                     mismatch_count;
   int                     outstanding;
   logic                   calm;
   int                     gap_odds;

   sliding_first_harmonic_power dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   harmonic_power_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int v;
      v = $urandom_range(0, 9);
      case (v)
         0:       pick_sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
         1:       pick_sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
         2:       pick_sample = '0;
         3, 4:    pick_sample = SAMPLE_W'($urandom_range(0, 511)) - SAMPLE_W'(256);
         default: pick_sample = SAMPLE_W'($urandom());
      endcase
   endfunction

   function automatic logic [REQ_TDATA_W-1:0] fill_block(input logic [SAMPLE_W-1:0] value);
      logic [REQ_TDATA_W-1:0] blk;
      for (int i = 0; i < SAMPLES_PER_BLOCK; i++)
         blk[i*SAMPLE_W +: SAMPLE_W] = value;
      return blk;
   endfunction

   function automatic logic [REQ_TDATA_W-1:0] random_block();
      logic [REQ_TDATA_W-1:0] blk;
      if ($urandom_range(0, 15) == 0)
         return fill_block(pick_sample());
      for (int i = 0; i < SAMPLES_PER_BLOCK; i++)
         blk[i*SAMPLE_W +: SAMPLE_W] = pick_sample();
      return blk;
   endfunction

   // call at a falling edge; returns at the falling edge after the beat is taken
   task automatic send_block(input logic [CHANNEL_W-1:0] ch,
                             input logic [REQ_TDATA_W-1:0] blk);
      if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_tvalid <= 1'b0;
         req_tdata  <= random_block();
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= ch;
      req_tdata  <= blk;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   initial begin : rsp_pacing
      int stall_odds;
      int cycle;
      stall_odds = 0;
      cycle = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(negedge clock);
         if (cycle % 200 == 0)
            stall_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 30);
         cycle++;
         if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
            cycle++;
         end
         rsp_tready <= 1'b1;
      end
   end

   initial begin : stimulus
      logic [SAMPLE_W-1:0]    max_pos;
      logic [SAMPLE_W-1:0]    max_neg;
      logic [REQ_TDATA_W-1:0] blk;
      max_pos = {1'b0, {(SAMPLE_W-1){1'b1}}};
      max_neg = {1'b1, {(SAMPLE_W-1){1'b0}}};
      calm     = 1'b0;
      gap_odds = 4;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_block(2'd0, '0);
      for (int c = 0; c < 4; c++)
         send_block(CHANNEL_W'(c), fill_block(max_pos));
      for (int c = 0; c < 4; c++)
         send_block(CHANNEL_W'(c), fill_block(max_neg));
      // walk channel 2 through every phase with alternating extremes
      for (int n = 0; n < 6; n++) begin
         for (int i = 0; i < SAMPLES_PER_BLOCK; i++)
            blk[i*SAMPLE_W +: SAMPLE_W] = ((i + n) % 2 == 0) ? max_pos : max_neg;
         send_block(2'd2, blk);
      end
      blk = '0;
      blk[0 +: SAMPLE_W] = max_neg;
      send_block(2'd3, blk);
      blk = '0;
      blk[(SAMPLES_PER_BLOCK-1)*SAMPLE_W +: SAMPLE_W] = max_pos;
      send_block(2'd3, blk);
      send_block(2'd1, fill_block('1));
      send_block(2'd1, fill_block(SAMPLE_W'(1)));

      for (int n = 0; n < RANDOM_BLOCKS; n++) begin
         if (n % 50 == 0)
            gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
         calm = (n >= RANDOM_BLOCKS - CALM_BLOCKS);
         send_block(CHANNEL_W'($urandom_range(0, 3)), random_block());
      end
      req_tvalid <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
